// ===== rtl/ksl_pkg.sv =====
package ksl_pkg;

  localparam int KEY_W     = 64;
  localparam int KLEN_W    = 4;
  localparam int MAX_KEY_BYTES = 8;
  localparam int CHAR_W    = 8;
  localparam int OFS_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_BARE  = 2'd1;
  localparam logic [1:0] ST_VALUE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARATOR = 2'd3;

  typedef enum logic [2:0] {
    PH_SEG_SKIP,
    PH_KEY_CMP,
    PH_POST_KEY,
    PH_VAL_SKIP,
    PH_VAL_QUOTED,
    PH_VAL_PLAIN,
    PH_TO_SEP
  } phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] data_byte;
    logic              last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]       lookup_status;
    logic [OFS_W-1:0] found_offset;
    logic [OFS_W-1:0] value_length;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_bytes;
    logic [KLEN_W-1:0] key_length;
    logic [CHAR_W-1:0] separator_char;
    logic [CHAR_W-1:0] comparator_char;
  } cfg_t;

endpackage

// ===== rtl/ksl_scan.sv =====
module ksl_scan #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  ksl_pkg::in_t  item,
  input  ksl_pkg::cfg_t cfg,
  output logic          res_valid,
  output ksl_pkg::out_t res
);

  localparam int PW = POSITION_WIDTH;
  localparam int OW = ksl_pkg::OFS_W;
  localparam logic [ksl_pkg::KLEN_W-1:0] KLEN_MAX = ksl_pkg::KLEN_W'(ksl_pkg::MAX_KEY_BYTES);

  ksl_pkg::phase_t             phase, phase_step;
  logic [ksl_pkg::KLEN_W-1:0]  count, count_step;
  logic [PW-1:0]               pos, kstart, kstart_step, vstart, vstart_step;
  logic [PW-1:0]               vend, vend_step;
  logic [ksl_pkg::CHAR_W-1:0]  quote, quote_step;
  logic                        sent;

  logic [ksl_pkg::CHAR_W-1:0]  b, sep, comp, kb;
  logic [ksl_pkg::KLEN_W-1:0]  klen, cnt_in, cnt_inc;
  logic                        do_cmp;

  assign b    = item.data_byte;
  assign sep  = cfg.separator_char;
  assign comp = cfg.comparator_char;
  assign klen = (cfg.key_length > KLEN_MAX) ? KLEN_MAX : cfg.key_length;

  // next state for the current byte, before the end-of-buffer clear
  always_comb begin
    phase_step  = phase;
    count_step  = count;
    kstart_step = kstart;
    vstart_step = vstart;
    vend_step   = vend;
    quote_step  = quote;
    do_cmp      = 1'b0;
    cnt_in      = count;
    if (!sent) begin
      case (phase)
        ksl_pkg::PH_SEG_SKIP: begin
          if (b != ksl_pkg::CH_SPACE) begin
            kstart_step = pos;
            cnt_in      = '0;
            do_cmp      = 1'b1;
          end
        end
        ksl_pkg::PH_KEY_CMP: begin
          do_cmp = 1'b1;
        end
        ksl_pkg::PH_POST_KEY: begin
          if (b != ksl_pkg::CH_SPACE && b != sep) begin
            if (comp != ksl_pkg::CH_NUL && b == comp) begin
              phase_step = ksl_pkg::PH_VAL_SKIP;
            end else begin
              phase_step = ksl_pkg::PH_TO_SEP;
            end
          end
        end
        ksl_pkg::PH_VAL_SKIP: begin
          if (b != ksl_pkg::CH_SPACE) begin
            if (b == ksl_pkg::CH_SQUOTE || b == ksl_pkg::CH_DQUOTE) begin
              quote_step  = b;
              vstart_step = pos + PW'(1);
              phase_step  = ksl_pkg::PH_VAL_QUOTED;
            end else begin
              vstart_step = pos;
              if (b != sep) begin
                vend_step  = pos + PW'(1);
                phase_step = ksl_pkg::PH_VAL_PLAIN;
              end
            end
          end
        end
        ksl_pkg::PH_VAL_QUOTED: begin
        end
        ksl_pkg::PH_VAL_PLAIN: begin
          if (b != sep && b != ksl_pkg::CH_SPACE) begin
            vend_step = pos + PW'(1);
          end
        end
        ksl_pkg::PH_TO_SEP: begin
          if (b == sep) begin
            phase_step = ksl_pkg::PH_SEG_SKIP;
          end
        end
        default: begin
        end
      endcase
    end

    kb      = cfg.key_bytes[{cnt_in[2:0], 3'b000} +: ksl_pkg::CHAR_W];
    cnt_inc = cnt_in + ksl_pkg::KLEN_W'(1);
    if (do_cmp) begin
      count_step = cnt_in;
      if (klen == '0) begin
        phase_step = ksl_pkg::PH_TO_SEP;
      end else if (b == sep) begin
        // separator inside the key ends the segment as a mismatch
        phase_step = ksl_pkg::PH_SEG_SKIP;
      end else if (b != kb || cnt_in >= klen) begin
        phase_step = ksl_pkg::PH_TO_SEP;
      end else begin
        count_step = cnt_inc;
        phase_step = (cnt_inc >= klen) ? ksl_pkg::PH_POST_KEY : ksl_pkg::PH_KEY_CMP;
      end
    end
  end

  // result for the current byte
  always_comb begin
    logic          emit;
    logic [1:0]    status;
    logic [PW-1:0] off;
    logic [PW-1:0] len;
    emit   = 1'b0;
    status = ksl_pkg::ST_NONE;
    off    = '0;
    len    = '0;
    if (!sent) begin
      case (phase)
        ksl_pkg::PH_POST_KEY: begin
          if (b != ksl_pkg::CH_SPACE && b == sep) begin
            emit = 1'b1;
            if (comp == ksl_pkg::CH_NUL) begin
              status = ksl_pkg::ST_BARE;
              off    = kstart;
            end
          end
        end
        ksl_pkg::PH_VAL_SKIP: begin
          if (b != ksl_pkg::CH_SPACE && b != ksl_pkg::CH_SQUOTE &&
              b != ksl_pkg::CH_DQUOTE && b == sep) begin
            emit   = 1'b1;
            status = ksl_pkg::ST_VALUE;
            off    = pos;
          end
        end
        ksl_pkg::PH_VAL_QUOTED: begin
          if (b == quote) begin
            emit   = 1'b1;
            status = ksl_pkg::ST_VALUE;
            off    = vstart;
            len    = pos - vstart;
          end
        end
        ksl_pkg::PH_VAL_PLAIN: begin
          if (b == sep) begin
            emit   = 1'b1;
            status = ksl_pkg::ST_VALUE;
            off    = vstart;
            len    = vend - vstart;
          end
        end
        default: begin
        end
      endcase

      // end of buffer with nothing decided: report from the updated scan
      if (!emit && item.last_byte) begin
        emit = 1'b1;
        case (phase_step)
          ksl_pkg::PH_POST_KEY: begin
            if (comp == ksl_pkg::CH_NUL) begin
              status = ksl_pkg::ST_BARE;
              off    = kstart_step;
            end
          end
          ksl_pkg::PH_VAL_SKIP: begin
            status = ksl_pkg::ST_VALUE;
            off    = pos + PW'(1);
          end
          ksl_pkg::PH_VAL_QUOTED: begin
            status = ksl_pkg::ST_VALUE;
            off    = vstart_step;
            len    = pos + PW'(1) - vstart_step;
          end
          ksl_pkg::PH_VAL_PLAIN: begin
            status = ksl_pkg::ST_VALUE;
            off    = vstart_step;
            len    = vend_step - vstart_step;
          end
          default: begin
          end
        endcase
      end
    end
    res_valid         = emit;
    res.lookup_status = status;
    res.found_offset  = OW'(off);
    res.value_length  = OW'(len);
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      phase  <= ksl_pkg::PH_SEG_SKIP;
      count  <= '0;
      pos    <= '0;
      kstart <= '0;
      vstart <= '0;
      vend   <= '0;
      quote  <= '0;
      sent   <= 1'b0;
    end else if (step) begin
      phase  <= phase_step;
      count  <= count_step;
      pos    <= pos + PW'(1);
      kstart <= kstart_step;
      vstart <= vstart_step;
      vend   <= vend_step;
      quote  <= quote_step;
      sent   <= sent | res_valid;
    end
  end

`ifndef SYNTH
  a_last_reports: assert property (@(posedge clk) disable iff (rst)
    step && item.last_byte && !sent |-> res_valid)
    else $error("last byte of a buffer without a pending result gave none");

  a_one_per_buffer: assert property (@(posedge clk) disable iff (rst)
    sent |-> !res_valid)
    else $error("second result within one buffer");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && item.last_byte |=> pos == '0 && !sent && phase == ksl_pkg::PH_SEG_SKIP)
    else $error("scan state not cleared after the last byte");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.lookup_status != 2'd3)
    else $error("undefined lookup status");

  a_len_only_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.lookup_status != ksl_pkg::ST_VALUE |-> res.value_length == '0)
    else $error("nonzero length without a value");
`endif

endmodule

// ===== rtl/keyed_substring_lookup_top.sv =====
// A result appears on out_* in the cycle after the byte that decides it.
// Throughput: one byte per cycle while no result is stalled; the scan state updates
// once per byte. A byte enters in the cycle that a waiting result transfers; a stalled result holds the input.
// At most one result per buffer; remaining bytes after it are consumed silently.
// Reset (rst, synchronous, active high) restores the registers to key 0,
// length 1, separator ';', comparator '=' and returns the scan to segment start.
module keyed_substring_lookup_top #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ksl_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ksl_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ksl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ksl_pkg::KEY_W-1:0]          cfg_data
);

  ksl_pkg::cfg_t cfg;
  ksl_pkg::out_t res;
  logic          res_valid;
  logic          in_xfer;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_bytes       <= '0;
      cfg.key_length      <= ksl_pkg::KLEN_W'(1);
      cfg.separator_char  <= 8'd59;
      cfg.comparator_char <= 8'd61;
    end else if (cfg_valid) begin
      case (cfg_index)
        ksl_pkg::REG_KEY_BYTES:  cfg.key_bytes       <= cfg_data;
        ksl_pkg::REG_KEY_LENGTH: cfg.key_length      <= cfg_data[ksl_pkg::KLEN_W-1:0];
        ksl_pkg::REG_SEPARATOR:  cfg.separator_char  <= cfg_data[ksl_pkg::CHAR_W-1:0];
        ksl_pkg::REG_COMPARATOR: cfg.comparator_char <= cfg_data[ksl_pkg::CHAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ksl_scan #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .step     (in_xfer),
    .item     (in_data),
    .cfg      (cfg),
    .res_valid(res_valid),
    .res      (res)
  );

  // hold the result until its transfer; a new one may load in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      out_data <= res;
    end
  end

`ifndef SYNTH
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    in_xfer && res_valid |=> out_valid && out_data == $past(res))
    else $error("result not loaded into the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_xfer)
    else $error("byte taken while a result is stalled");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !(in_xfer && res_valid) |=> !out_valid)
    else $error("output stayed valid after its transfer");
`endif

endmodule
